[rtl/core/bdpt_pkg.sv]
package bdpt_pkg;

  localparam int DEFAULT_NUM_BUTTONS   = 4;
  localparam int DEFAULT_SECONDS_WIDTH = 8;
  localparam int CFG_W                 = 16;
  localparam int CFG_INDEX_W           = 2;
  localparam int TICK_W                = 16;
  localparam int HELD_W                = 8;
  localparam int QUEUE_DEPTH           = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEBOUNCE_TICKS   = 2'd0,
    CFG_TICKS_PER_SECOND = 2'd1,
    CFG_ACTIVE_LOW_MASK  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_PRESS    = 2'd0,
    EV_RELEASE  = 2'd1,
    EV_PERIODIC = 2'd2
  } event_code_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[rtl/core/button_debounce_press_timer.sv]
// Debouncer with press, release and held-second events for NUM_BUTTONS buttons.
// Each transaction on the input side is one tick of raw pin levels; the front
// updates every button's debounce and hold timers in the cycle the tick is
// taken, so a tick can be accepted in every cycle while the two-deep event
// queue between front and back has room. The back hands out the events of a
// tick one per cycle while pop is high, periodic before debounce result per
// button and buttons in index order, with last_event on the final one; a tick
// carries up to 2 x NUM_BUTTONS events, so the sustained tick rate is set by
// how fast results are popped. Ticks that cause no event pass without using the
// queue. Configuration writes are taken in every cycle (cfg_ready is always
// high) and must be made while no events are pending.
module button_debounce_press_timer import bdpt_pkg::*; #(
  parameter int NUM_BUTTONS   = DEFAULT_NUM_BUTTONS,
  parameter int SECONDS_WIDTH = DEFAULT_SECONDS_WIDTH,
  parameter int IDX_W         = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [NUM_BUTTONS-1:0] pin_levels,
  output logic                   empty,
  input  logic                   pop,
  output logic [IDX_W-1:0]       button_index,
  output logic [1:0]             event_code,
  output logic [HELD_W-1:0]      held_seconds,
  output logic                   last_event,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int REC_W = 3 * NUM_BUTTONS + 2 * NUM_BUTTONS * HELD_W;

  queue_status_t    q_status;
  logic             accept;
  logic             rec_valid;
  logic [REC_W-1:0] rec;
  logic [REC_W-1:0] q_data;
  logic             q_pop;

  assign full      = q_status.full;
  assign accept    = push && !q_status.full;
  assign cfg_ready = 1'b1;

  bdpt_front #(
    .NUM_BUTTONS   (NUM_BUTTONS),
    .SECONDS_WIDTH (SECONDS_WIDTH),
    .REC_W         (REC_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tick_valid (accept),
    .pin_levels (pin_levels),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  bdpt_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_valid),
    .wr_data (rec),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .status  (q_status)
  );

  bdpt_back #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .IDX_W       (IDX_W),
    .REC_W       (REC_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .button_index (button_index),
    .event_code   (event_code),
    .held_seconds (held_seconds),
    .last_event   (last_event)
  );

endmodule

[rtl/core/bdpt_queue.sv]
module bdpt_queue import bdpt_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output queue_status_t    status
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + COUNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

  assign rd_data      = entries[rd_ptr];
  assign status.full  = (count == COUNT_W'(DEPTH));
  assign status.empty = (count == '0);

endmodule

[rtl/core/bdpt_front.sv]
module bdpt_front import bdpt_pkg::*; #(
  parameter int NUM_BUTTONS   = DEFAULT_NUM_BUTTONS,
  parameter int SECONDS_WIDTH = DEFAULT_SECONDS_WIDTH,
  parameter int REC_W         = 3 * NUM_BUTTONS + 2 * NUM_BUTTONS * HELD_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   tick_valid,
  input  logic [NUM_BUTTONS-1:0] pin_levels,
  output logic                   rec_valid,
  output logic [REC_W-1:0]       rec
);

  localparam int SLOTS = 2 * NUM_BUTTONS;
  localparam int EXT_W = SECONDS_WIDTH + HELD_W;

  logic [TICK_W-1:0]      debounce_ticks;
  logic [TICK_W-1:0]      ticks_per_second;
  logic [NUM_BUTTONS-1:0] active_low_mask;

  logic [NUM_BUTTONS-1:0]   previous_levels;
  logic [NUM_BUTTONS-1:0]   debounce_running;
  logic [NUM_BUTTONS-1:0]   debounce_running_next;
  logic [TICK_W-1:0]        debounce_remaining      [NUM_BUTTONS];
  logic [TICK_W-1:0]        debounce_remaining_next [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0]   hold_running;
  logic [NUM_BUTTONS-1:0]   hold_running_next;
  logic [TICK_W-1:0]        hold_remaining          [NUM_BUTTONS];
  logic [TICK_W-1:0]        hold_remaining_next     [NUM_BUTTONS];
  logic [SECONDS_WIDTH-1:0] seconds_held            [NUM_BUTTONS];
  logic [SECONDS_WIDTH-1:0] seconds_held_next       [NUM_BUTTONS];

  logic [TICK_W-1:0]      deb;
  logic [TICK_W-1:0]      sec;
  logic [TICK_W-1:0]      first_load;
  logic [NUM_BUTTONS-1:0] pressed;
  logic [NUM_BUTTONS-1:0] level_edge;
  logic [TICK_W-1:0]      hold_dec [NUM_BUTTONS];
  logic [TICK_W-1:0]      deb_dec  [NUM_BUTTONS];
  logic [EXT_W-1:0]       secs_ext [NUM_BUTTONS];

  logic [SLOTS-1:0]             rec_mask;
  logic [NUM_BUTTONS-1:0]       rec_release;
  logic [SLOTS-1:0][HELD_W-1:0] rec_secs;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= TICK_W'(2);
      ticks_per_second <= TICK_W'(128);
      active_low_mask  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg_data[TICK_W-1:0];
        CFG_TICKS_PER_SECOND: ticks_per_second <= cfg_data[TICK_W-1:0];
        CFG_ACTIVE_LOW_MASK:  active_low_mask  <= cfg_data[NUM_BUTTONS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    deb        = (debounce_ticks == '0) ? TICK_W'(1) : debounce_ticks;
    sec        = (ticks_per_second == '0) ? TICK_W'(1) : ticks_per_second;
    first_load = (sec > deb) ? sec - deb : TICK_W'(1);
    pressed    = pin_levels ^ active_low_mask;
    level_edge = pin_levels ^ previous_levels;

    rec_mask              = '0;
    rec_release           = '0;
    rec_secs              = '0;
    hold_running_next     = hold_running;
    debounce_running_next = debounce_running;

    for (int i = 0; i < NUM_BUTTONS; i++) begin
      hold_dec[i]                = hold_remaining[i] - TICK_W'(1);
      deb_dec[i]                 = debounce_remaining[i] - TICK_W'(1);
      hold_remaining_next[i]     = hold_remaining[i];
      debounce_remaining_next[i] = debounce_remaining[i];
      seconds_held_next[i]       = seconds_held[i];

      // hold timer first
      if (hold_running[i]) begin
        hold_remaining_next[i] = hold_dec[i];
        if (hold_dec[i] == '0) begin
          if (seconds_held[i] != '1) begin
            seconds_held_next[i] = seconds_held[i] + SECONDS_WIDTH'(1);
          end
          hold_remaining_next[i] = sec;
          rec_mask[2*i]          = 1'b1;
        end
      end
      secs_ext[i]    = {{HELD_W{1'b0}}, seconds_held_next[i]};
      rec_secs[2*i]  = secs_ext[i][HELD_W-1:0];

      // then debounce end
      if (debounce_running[i]) begin
        debounce_remaining_next[i] = deb_dec[i];
        if (deb_dec[i] == '0) begin
          debounce_running_next[i] = 1'b0;
          if (pressed[i] && !hold_running[i]) begin
            seconds_held_next[i]   = '0;
            hold_remaining_next[i] = first_load;
            hold_running_next[i]   = 1'b1;
            rec_mask[2*i+1]        = 1'b1;
          end else if (!pressed[i] && hold_running[i]) begin
            hold_running_next[i]   = 1'b0;
            hold_remaining_next[i] = '0;
            rec_mask[2*i+1]        = 1'b1;
            rec_release[i]         = 1'b1;
            rec_secs[2*i+1]        = secs_ext[i][HELD_W-1:0];
          end
        end
      end

      if (level_edge[i] && !debounce_running_next[i]) begin
        debounce_running_next[i]   = 1'b1;
        debounce_remaining_next[i] = deb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_levels  <= '0;
      debounce_running <= '0;
      hold_running     <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        debounce_remaining[i] <= '0;
        hold_remaining[i]     <= '0;
        seconds_held[i]       <= '0;
      end
    end else if (tick_valid) begin
      previous_levels  <= pin_levels;
      debounce_running <= debounce_running_next;
      hold_running     <= hold_running_next;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        debounce_remaining[i] <= debounce_remaining_next[i];
        hold_remaining[i]     <= hold_remaining_next[i];
        seconds_held[i]       <= seconds_held_next[i];
      end
    end
  end

  assign rec_valid = tick_valid && (rec_mask != '0);
  assign rec       = {rec_secs, rec_release, rec_mask};

endmodule

[rtl/core/bdpt_back.sv]
module bdpt_back import bdpt_pkg::*; #(
  parameter int NUM_BUTTONS = DEFAULT_NUM_BUTTONS,
  parameter int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1,
  parameter int REC_W       = 3 * NUM_BUTTONS + 2 * NUM_BUTTONS * HELD_W
) (
  input  logic              clk,
  input  logic              rst,
  input  queue_status_t     q_status,
  input  logic [REC_W-1:0]  q_data,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [IDX_W-1:0]  button_index,
  output logic [1:0]        event_code,
  output logic [HELD_W-1:0] held_seconds,
  output logic              last_event
);

  localparam int SLOTS  = 2 * NUM_BUTTONS;
  localparam int SLOT_W = $clog2(SLOTS);

  logic [SLOTS-1:0]             cur_mask;
  logic [NUM_BUTTONS-1:0]       cur_release;
  logic [SLOTS-1:0][HELD_W-1:0] cur_secs;

  logic [SLOT_W-1:0] sel;
  logic [SLOTS-1:0]  remaining;
  logic [IDX_W-1:0]  btn;
  logic              take;
  logic              load;
  event_code_t       code;

  always_comb begin
    sel = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (cur_mask[s]) begin
        sel = SLOT_W'(s);
      end
    end
  end

  assign remaining = cur_mask & ~(SLOTS'(1) << sel);
  assign empty     = (cur_mask == '0);
  assign take      = pop && !empty;
  assign load      = !q_status.empty && (empty || (take && (remaining == '0)));
  assign q_pop     = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask <= '0;
    end else if (load) begin
      cur_mask <= q_data[SLOTS-1:0];
    end else if (take) begin
      cur_mask <= remaining;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_release <= q_data[SLOTS+NUM_BUTTONS-1:SLOTS];
      cur_secs    <= q_data[REC_W-1:SLOTS+NUM_BUTTONS];
    end
  end

  // even slot periodic, odd slot debounce result
  always_comb begin
    btn = IDX_W'(sel >> 1);
    if (!sel[0]) begin
      code = EV_PERIODIC;
    end else if (cur_release[btn]) begin
      code = EV_RELEASE;
    end else begin
      code = EV_PRESS;
    end
  end

  assign button_index = btn;
  assign event_code   = code;
  assign held_seconds = cur_secs[sel];
  assign last_event   = (remaining == '0);

endmodule

[test/tb_top.sv]
import bdpt_pkg::*;

typedef struct packed {
  logic [1:0]  button;
  event_code_t code;
  logic [7:0]  secs;
  logic        last;
} button_event_t;

class press_timer_scoreboard;
  logic [15:0]   debounce_len;
  logic [15:0]   second_len;
  logic [3:0]    low_mask;
  logic [3:0]    prev_levels;
  logic [3:0]    deb_busy;
  logic [3:0]    hold_busy;
  logic [15:0]   deb_left [4];
  logic [15:0]   hold_left [4];
  logic [7:0]    held [4];
  button_event_t pending [$];
  int            errors;
  int            checked;
  int            ticks;
  int            periodics;
  int            top_held;

  function new();
    debounce_len = 16'd2;
    second_len   = 16'd128;
    low_mask     = '0;
    prev_levels  = '0;
    deb_busy     = '0;
    hold_busy    = '0;
    foreach (held[b]) begin
      deb_left[b]  = '0;
      hold_left[b] = '0;
      held[b]      = '0;
    end
    errors    = 0;
    checked   = 0;
    ticks     = 0;
    periodics = 0;
    top_held  = 0;
  endfunction

  function void set_reg(cfg_reg_t idx, logic [15:0] data);
    case (idx)
      CFG_DEBOUNCE_TICKS:   debounce_len = data;
      CFG_TICKS_PER_SECOND: second_len = data;
      CFG_ACTIVE_LOW_MASK:  low_mask = data[3:0];
      default: ;
    endcase
  endfunction

  function void note_tick(logic [3:0] levels);
    logic [15:0] deb;
    logic [15:0] sec;
    logic        pressed;
    int          first;
    deb   = (debounce_len == 16'd0) ? 16'd1 : debounce_len;
    sec   = (second_len == 16'd0) ? 16'd1 : second_len;
    first = pending.size();
    ticks++;
    for (int b = 0; b < 4; b++) begin
      if (hold_busy[b]) begin
        hold_left[b] = hold_left[b] - 16'd1;
        if (hold_left[b] == 16'd0) begin
          if (held[b] != 8'hFF) held[b] = held[b] + 8'd1;
          hold_left[b] = sec;
          pending.push_back('{button: 2'(b), code: EV_PERIODIC, secs: held[b], last: 1'b0});
        end
      end
      if (deb_busy[b]) begin
        deb_left[b] = deb_left[b] - 16'd1;
        if (deb_left[b] == 16'd0) begin
          pressed     = levels[b] ^ low_mask[b];
          deb_busy[b] = 1'b0;
          if (pressed && !hold_busy[b]) begin
            held[b]      = '0;
            hold_left[b] = (sec > deb) ? sec - deb : 16'd1;
            hold_busy[b] = 1'b1;
            pending.push_back('{button: 2'(b), code: EV_PRESS, secs: 8'd0, last: 1'b0});
          end else if (!pressed && hold_busy[b]) begin
            hold_busy[b] = 1'b0;
            hold_left[b] = '0;
            pending.push_back('{button: 2'(b), code: EV_RELEASE, secs: held[b], last: 1'b0});
          end
        end
      end
      if (levels[b] != prev_levels[b] && !deb_busy[b]) begin
        deb_busy[b] = 1'b1;
        deb_left[b] = deb;
      end
    end
    prev_levels = levels;
    if (pending.size() > first) pending[pending.size() - 1].last = 1'b1;
  endfunction

  task report(string what);
    errors++;
    if (errors <= 50) $display("mismatch: %s", what);
  endtask

  task check_event(logic [1:0] button, logic [1:0] code, logic [7:0] secs, logic last);
    button_event_t want;
    if (pending.size() == 0) begin
      report($sformatf("transaction with nothing pending: button %0d code %0d held %0d",
                       button, code, secs));
    end else begin
      want = pending.pop_front();
      checked++;
      if (want.code == EV_PERIODIC) periodics++;
      if (int'(want.secs) > top_held) top_held = want.secs;
      if (button !== want.button)
        report($sformatf("transaction %0d: button %0d, expected %0d",
                         checked, button, want.button));
      if (code !== want.code)
        report($sformatf("transaction %0d: event code %0d, expected %0d",
                         checked, code, want.code));
      if (secs !== want.secs)
        report($sformatf("transaction %0d: held seconds %0d, expected %0d",
                         checked, secs, want.secs));
      if (last !== want.last)
        report($sformatf("transaction %0d: last flag %0d, expected %0d",
                         checked, last, want.last));
    end
  endtask
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 4;
  localparam int TAIL        = 16;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   push       = 1'b0;
  logic                   pop        = 1'b0;
  logic [3:0]             pin_levels = '0;
  logic                   cfg_valid  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]       cfg_data   = '0;
  logic                   full;
  logic                   empty;
  logic [1:0]             button_index;
  logic [1:0]             event_code;
  logic [HELD_W-1:0]      held_seconds;
  logic                   last_event;
  logic                   cfg_ready;

  int gap_odds     = 0;
  int pop_odds     = 0;
  int pop_hold     = 0;
  int stall_cycles = 0;
  int reg_writes   = 0;

  press_timer_scoreboard sb = new();

  logic [3:0] plain_ticks [12] = '{4'h0, 4'hF, 4'hF, 4'hF, 4'h0, 4'h1,
                                   4'h0, 4'h0, 4'h5, 4'hA, 4'h5, 4'hA};
  logic [3:0] fast_ticks [8]   = '{4'h0, 4'h0, 4'hF, 4'hF, 4'hF, 4'h0, 4'h0, 4'h0};
  logic [3:0] inv_ticks [5]    = '{4'hF, 4'h0, 4'h0, 4'h0, 4'hF};

  button_debounce_press_timer i_dut (
    .clk,
    .rst,
    .push,
    .full,
    .pin_levels,
    .empty,
    .pop,
    .button_index,
    .event_code,
    .held_seconds,
    .last_event,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop      <= 1'b0;
    end else if (pop_odds != 0 && $urandom_range(1, 100) <= pop_odds) begin
      pop_hold <= $urandom_range(0, 6);
      pop      <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (push && !full) sb.note_tick(pin_levels);
      if (pop && !empty) sb.check_event(button_index, event_code, held_seconds, last_event);
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("button_debounce_press_timer regression: fail");
    $finish;
  end

  task automatic send_tick(input logic [3:0] levels);
    if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    push       <= 1'b1;
    pin_levels <= levels;
    do @(posedge clk); while (full);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic configure(input logic [15:0] deb, input logic [15:0] sec,
                           input logic [3:0] mask);
    wait_drained();
    write_reg(CFG_DEBOUNCE_TICKS, deb);
    write_reg(CFG_TICKS_PER_SECOND, sec);
    write_reg(CFG_ACTIVE_LOW_MASK, {12'h000, mask});
  endtask

  // held patterns with bounce on the first tick, plus some pure noise
  task automatic play_presses(input int n);
    int         sent;
    int         hold;
    int         kind;
    logic [3:0] pattern;
    logic [3:0] lv;
    sent = 0;
    while (sent < n) begin
      pattern = 4'($urandom_range(0, 15));
      hold    = $urandom_range(1, 12);
      kind    = $urandom_range(0, 9);
      for (int k = 0; k < hold && sent < n; k++) begin
        lv = pattern;
        if (kind == 9)
          lv = 4'($urandom_range(0, 15));
        else if (kind >= 7 && k == 0)
          lv = pattern ^ (4'b0001 << $urandom_range(0, 3));
        send_tick(lv);
        sent++;
      end
    end
  endtask

  initial begin
    logic [3:0] lv;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gap_odds = 15;
    pop_odds = 15;

    foreach (plain_ticks[k]) send_tick(plain_ticks[k]);
    configure(16'd0, 16'd0, 4'h0);
    foreach (fast_ticks[k]) send_tick(fast_ticks[k]);
    configure(16'd1, 16'd1, 4'hF);
    foreach (inv_ticks[k]) send_tick(inv_ticks[k]);

    // longest second, every button pressed then released
    configure(16'd2, 16'hFFFF, 4'h0);
    gap_odds = 0;
    repeat (4) send_tick(4'hF);
    repeat (4) send_tick(4'h0);
    gap_odds = 15;

    // one-tick seconds, held count climbs every tick
    configure(16'd1, 16'd1, 4'h0);
    lv = 4'($urandom_range(1, 15));
    repeat (40) send_tick(lv | (4'($urandom_range(0, 15)) & ~lv));
    repeat (3) send_tick(4'h0);

    for (int ph = 0; ph < 6; ph++) begin
      configure(16'($urandom_range(1, 4)), 16'($urandom_range(2, 9)),
                4'($urandom_range(0, 15)));
      gap_odds = (ph == 2 || ph == 5) ? 0 : 5 + 5 * ph;
      pop_odds = (ph == 2 || ph == 5) ? 0 : 30 - 5 * ph;
      play_presses(16);
    end

    wait_drained();
    repeat (TAIL) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d events never arrived", sb.pending.size()));

    $display("%0d ticks under %0d register writes, second lengths from 0 up to 65535",
             sb.ticks, reg_writes);
    $display("%0d events checked, %0d held-second, held count reached %0d",
             sb.checked, sb.periodics, sb.top_held);
    if (sb.errors == 0)
      $display("button_debounce_press_timer regression: pass");
    else
      $display("button_debounce_press_timer regression: fail");
    $finish;
  end

endmodule

[sim.f]
rtl/core/bdpt_pkg.sv
rtl/core/bdpt_queue.sv
rtl/core/bdpt_front.sv
rtl/core/bdpt_back.sv
rtl/core/button_debounce_press_timer.sv
test/tb_top.sv
